### hdl/flme_pkg.sv
// ----------------------------------------------------------------------------
// flme_pkg
// Shared types and constants of the fixed-latency memory endpoint.
// ----------------------------------------------------------------------------
package flme_pkg;

    // Fixed field widths of the stream and register interfaces
    localparam int ADDR_W      = 10;
    localparam int WDATA_W     = 64;
    localparam int REQ_W       = 2;
    localparam int LAT_W       = 10;
    localparam int LIMIT_W     = 5;
    localparam int OCC_W       = 5;
    localparam int IN_USED_W   = ADDR_W + WDATA_W + 2;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W  = 3 + ADDR_W + WDATA_W + 1 + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    // Request kinds carried in s_axis_tuser
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_RESP_LATENCY = 1'b0;
    localparam logic REG_QUEUE_LIMIT  = 1'b1;

    localparam logic [LAT_W-1:0]   LAT_RESET   = 10'd10;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_EVAL,
        BK_COMMIT
    } back_state_t;

    // Classified tick, front end to back end
    typedef struct packed {
        logic is_req;
        logic is_write;
        logic resp_retry;
        logic peer_ready;
    } cmd_flags_t;

    // Back end status seen by the front end
    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

### hdl/flme_front.sv
// ----------------------------------------------------------------------------
// flme_front
// Input register: accepts one tick transaction, classifies it and computes
// the memory word index before handing it to the command queue.
// ----------------------------------------------------------------------------
module flme_front #(
    parameter int MEM_WORDS = 1024,
    parameter int DATA_BITS = 64,
    localparam int MEM_AW   = $clog2(MEM_WORDS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [flme_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [flme_pkg::REQ_W-1:0]       s_axis_tuser,
    input  flme_pkg::back_status_t           status,
    output logic                             push_valid,
    input  logic                             push_ready,
    output flme_pkg::cmd_flags_t             push_flags,
    output logic [flme_pkg::ADDR_W-1:0]      push_address,
    output logic [MEM_AW-1:0]                push_word,
    output logic [DATA_BITS-1:0]             push_data
);
    import flme_pkg::*;

    // quotient of address / MEM_WORDS is below 2^(ADDR_W-4) since MEM_WORDS >= 16
    localparam int MOD_STEPS = ADDR_W - 4;

    logic                  item_valid_reg;
    logic                  item_valid_next;
    logic [REQ_W-1:0]      item_type_reg;
    logic [IN_USED_W-1:0]  item_data_reg;
    logic                  take;
    logic [ADDR_W-1:0]     item_addr;
    logic [WDATA_W-1:0]    item_wdata;
    logic [ADDR_W-1:0]     rem;

    assign s_axis_tready   = !status.clearing && (!item_valid_reg || push_ready);
    assign take            = s_axis_tvalid && s_axis_tready;
    assign item_valid_next = take || (item_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_type_reg <= s_axis_tuser;
            item_data_reg <= s_axis_tdata[IN_USED_W-1:0];
        end
    end

    assign item_addr  = item_data_reg[ADDR_W-1:0];
    assign item_wdata = item_data_reg[ADDR_W +: WDATA_W];

    // restoring remainder, one conditional subtract per quotient bit
    always_comb
    begin
        rem = item_addr;
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if (32'(rem) >= (32'(MEM_WORDS) << k))
            begin
                rem = rem - ADDR_W'(32'(MEM_WORDS) << k);
            end
        end
    end

    assign push_valid            = item_valid_reg;
    assign push_flags.is_req     = (item_type_reg == REQ_READ) || (item_type_reg == REQ_WRITE);
    assign push_flags.is_write   = (item_type_reg == REQ_WRITE);
    assign push_flags.resp_retry = item_data_reg[ADDR_W + WDATA_W];
    assign push_flags.peer_ready = item_data_reg[ADDR_W + WDATA_W + 1];
    assign push_address          = item_addr;
    assign push_word             = MEM_AW'(rem);
    assign push_data             = DATA_BITS'(item_wdata);

endmodule

### hdl/flme_cmd_fifo.sv
// ----------------------------------------------------------------------------
// flme_cmd_fifo
// Short first-word-fall-through queue between front and back end.
// ----------------------------------------------------------------------------
module flme_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != FW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        fill_next = fill_reg + FW'(do_push) - FW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/flme_back.sv
// ----------------------------------------------------------------------------
// flme_back
// Back end: request queue, word memory and the per-tick sequencer that
// services the head, delivers responses and admits new requests.
// ----------------------------------------------------------------------------
module flme_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MEM_WORDS   = 1024,
    parameter int DATA_BITS   = 64,
    parameter int TIME_BITS   = 16,
    localparam int MEM_AW     = $clog2(MEM_WORDS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [flme_pkg::LAT_W-1:0]       resp_latency,
    input  logic [flme_pkg::LIMIT_W-1:0]     queue_limit,
    input  logic                             cmd_valid,
    input  flme_pkg::cmd_flags_t             cmd_flags,
    input  logic [flme_pkg::ADDR_W-1:0]      cmd_address,
    input  logic [MEM_AW-1:0]                cmd_word,
    input  logic [DATA_BITS-1:0]             cmd_data,
    output logic                             cmd_pop,
    output flme_pkg::back_status_t           status,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [flme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tuser
);
    import flme_pkg::*;

    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    // request queue entries
    logic [ADDR_W-1:0]    entry_addr_reg     [QUEUE_DEPTH];
    logic                 entry_is_write_reg [QUEUE_DEPTH];
    logic [MEM_AW-1:0]    entry_word_reg     [QUEUE_DEPTH];
    logic [DATA_BITS-1:0] entry_data_reg     [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] entry_time_reg     [QUEUE_DEPTH];

    logic [DATA_BITS-1:0] word_mem [MEM_WORDS];
    logic [DATA_BITS-1:0] head_data_reg;

    back_state_t          state_reg, state_next;
    logic [MEM_AW-1:0]    clr_reg, clr_next;
    logic [QIW-1:0]       head_reg, head_next;
    logic [QIW-1:0]       tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 rqp_reg, rqp_next;
    logic                 rrp_reg, rrp_next;
    logic                 serviced_reg, serviced_next;
    logic                 deliver_reg, deliver_next;
    logic                 unexp_reg, unexp_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_tdata_reg, out_tdata_next;
    logic                 out_tuser_reg, out_tuser_next;

    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_wword;
    logic [DATA_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic                 push_entry;
    logic                 out_free;

    logic                 retry_hit;
    logic                 unexp_eval;
    logic                 rrp_eval;
    logic [TIME_BITS-1:0] time_diff;
    logic                 head_ready;
    logic [CW-1:0]        limit_eff;
    logic [CW-1:0]        cnt_pop;
    logic                 retry_fire;
    logic                 rqp_after;
    logic                 accept;
    logic [CW-1:0]        count_after;
    logic                 head_is_write;
    logic [WDATA_W-1:0]   resp_data;
    logic [ADDR_W-1:0]    resp_addr;

    function automatic logic [QIW-1:0] next_slot(input logic [QIW-1:0] idx);
        if (idx == QIW'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    // response side of a tick
    assign retry_hit  = cmd_flags.resp_retry && rrp_reg && (count_reg != '0);
    assign unexp_eval = cmd_flags.resp_retry && !retry_hit;
    assign rrp_eval   = rrp_reg && !retry_hit;
    assign time_diff  = time_reg - entry_time_reg[head_reg];
    assign head_ready = (count_reg != '0) && !rrp_eval && !time_diff[TIME_BITS-1];

    // request side of a tick
    assign limit_eff = (queue_limit == '0) ? CW'(1) :
                       ((32'(queue_limit) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : CW'(queue_limit));
    assign cnt_pop     = count_reg - CW'(deliver_reg);
    assign retry_fire  = deliver_reg && rqp_reg && (cnt_pop < limit_eff);
    assign rqp_after   = rqp_reg && !retry_fire;
    assign accept      = cmd_flags.is_req && !rqp_after && (cnt_pop < limit_eff);
    assign count_after = cnt_pop + CW'(accept);

    assign head_is_write = entry_is_write_reg[head_reg];
    assign resp_data     = (deliver_reg && !head_is_write) ? WDATA_W'(head_data_reg) : '0;
    assign resp_addr     = deliver_reg ? entry_addr_reg[head_reg] : '0;

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        time_next      = time_reg;
        rqp_next       = rqp_reg;
        rrp_next       = rrp_reg;
        serviced_next  = serviced_reg;
        deliver_next   = deliver_reg;
        unexp_next     = unexp_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_tdata_next = out_tdata_reg;
        out_tuser_next = out_tuser_reg;
        mem_we         = 1'b0;
        mem_wword      = clr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        push_entry     = 1'b0;
        cmd_pop        = 1'b0;

        case (state_reg)
            BK_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MEM_AW'(MEM_WORDS - 1))
                begin
                    state_next = BK_EVAL;
                end
            end
            BK_EVAL:
            begin
                if (cmd_valid)
                begin
                    rrp_next     = rrp_eval || (head_ready && !cmd_flags.peer_ready);
                    deliver_next = head_ready && cmd_flags.peer_ready;
                    unexp_next   = unexp_eval;
                    if (head_ready && !serviced_reg)
                    begin
                        serviced_next = 1'b1;
                        if (head_is_write)
                        begin
                            mem_we    = 1'b1;
                            mem_wword = entry_word_reg[head_reg];
                            mem_wdata = entry_data_reg[head_reg];
                        end
                        else
                        begin
                            mem_re = 1'b1;
                        end
                    end
                    state_next = BK_COMMIT;
                end
            end
            BK_COMMIT:
            begin
                if (out_free)
                begin
                    cmd_pop        = 1'b1;
                    out_valid_next = 1'b1;
                    out_tdata_next = {{OUT_PAD_W{1'b0}}, OCC_W'(count_after), unexp_reg,
                                      resp_data, resp_addr, deliver_reg, retry_fire, accept};
                    out_tuser_next = deliver_reg && head_is_write;
                    if (deliver_reg)
                    begin
                        head_next     = next_slot(head_reg);
                        serviced_next = 1'b0;
                    end
                    rqp_next = rqp_after || (cmd_flags.is_req && !accept);
                    if (accept)
                    begin
                        push_entry = 1'b1;
                        tail_next  = next_slot(tail_reg);
                    end
                    count_next = count_after;
                    time_next  = time_reg + 1'b1;
                    state_next = BK_EVAL;
                end
            end
            default:
            begin
                state_next = BK_EVAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            time_reg      <= '0;
            rqp_reg       <= 1'b0;
            rrp_reg       <= 1'b0;
            serviced_reg  <= 1'b0;
            deliver_reg   <= 1'b0;
            unexp_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            time_reg      <= time_next;
            rqp_reg       <= rqp_next;
            rrp_reg       <= rrp_next;
            serviced_reg  <= serviced_next;
            deliver_reg   <= deliver_next;
            unexp_reg     <= unexp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tdata_reg <= out_tdata_next;
        out_tuser_reg <= out_tuser_next;
        if (push_entry)
        begin
            entry_addr_reg[tail_reg]     <= cmd_address;
            entry_is_write_reg[tail_reg] <= cmd_flags.is_write;
            entry_word_reg[tail_reg]     <= cmd_word;
            entry_data_reg[tail_reg]     <= cmd_data;
            entry_time_reg[tail_reg]     <= time_reg + TIME_BITS'(resp_latency);
        end
    end

    // word memory, one write port, registered read into the head data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            word_mem[mem_wword] <= mem_wdata;
        end
        if (mem_re)
        begin
            head_data_reg <= word_mem[entry_word_reg[head_reg]];
        end
    end

    assign status.clearing = (state_reg == BK_CLEAR);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_tdata_reg;
    assign m_axis_tuser    = out_tuser_reg;

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with head and tail apart");

    a_rrp_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rrp_reg |-> (count_reg != '0))
        else $error("refused response pending with empty queue");

    a_serviced_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        serviced_reg |-> (count_reg != '0))
        else $error("serviced head flag with empty queue");

    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (time_reg == TIME_BITS'($past(time_reg) + 1'b1)))
        else $error("tick time did not advance by one");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_CLEAR) |-> (count_reg == '0 && !out_valid_reg))
        else $error("activity during memory clear");

endmodule

### hdl/fixed_latency_memory_endpoint.sv
// ----------------------------------------------------------------------------
// fixed_latency_memory_endpoint
// Memory endpoint that answers reads and writes in order after a fixed
// latency, with request and response retry handshakes.
// ----------------------------------------------------------------------------
// Every input transaction is one tick of the memory interface and yields
// exactly one output transaction. After reset the word memory is cleared
// one word a cycle, all MEM_WORDS words, with s_axis_tready low; APB writes
// are taken during that time. Afterwards the back-end sequencer first
// evaluates the head and accesses the word memory, then commits queue state
// and loads the output register, and it takes a new tick only after the
// last one is committed. The input register and a two-entry command queue
// decouple the input from the sequencer, and the output register decouples
// the sequencer from m_axis_tready. An accepted tick passes the input
// register, the command queue, the evaluate and commit states and the output
// register before its output transaction is offered. Configuration may only
// be changed while no tick is in flight.
// ----------------------------------------------------------------------------
module fixed_latency_memory_endpoint #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MEM_WORDS   = 1024,
    parameter int DATA_BITS   = 64,
    parameter int TIME_BITS   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tick input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] address, [73:10] write_data, [74] resp_retry, [75] peer_ready
    input  logic [flme_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [flme_pkg::REQ_W-1:0]       s_axis_tuser,
    // tick result
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] req_accepted, [1] request resend, [2] resp_valid, [12:3] resp_address,
    // [76:13] resp_data, [77] unexpected_retry, [82:78] occupancy
    output logic [flme_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] resp_is_write
    output logic                             m_axis_tuser,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [flme_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [flme_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [flme_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import flme_pkg::*;

    localparam int MEM_AW  = $clog2(MEM_WORDS);
    localparam int FLAGS_W = $bits(cmd_flags_t);
    localparam int CMD_W   = FLAGS_W + ADDR_W + MEM_AW + DATA_BITS;

    // configuration registers
    logic [LAT_W-1:0]   resp_latency_reg;
    logic [LIMIT_W-1:0] queue_limit_reg;
    logic               cfg_wr;
    logic               cfg_idx;

    // front end to command queue
    back_status_t       status;
    logic               front_valid;
    logic               front_ready;
    cmd_flags_t         front_flags;
    logic [ADDR_W-1:0]  front_address;
    logic [MEM_AW-1:0]  front_word;
    logic [DATA_BITS-1:0] front_data;
    logic [CMD_W-1:0]   fifo_in;

    // command queue to back end
    logic               cmd_valid;
    logic               cmd_pop;
    logic [CMD_W-1:0]   fifo_out;
    cmd_flags_t         cmd_flags;
    logic [ADDR_W-1:0]  cmd_address;
    logic [MEM_AW-1:0]  cmd_word;
    logic [DATA_BITS-1:0] cmd_data;

    // APB: no wait states, register index in paddr[2]
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_latency_reg <= LAT_RESET;
            queue_limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RESP_LATENCY: resp_latency_reg <= pwdata[LAT_W-1:0];
                REG_QUEUE_LIMIT:  queue_limit_reg  <= pwdata[LIMIT_W-1:0];
                default:          resp_latency_reg <= resp_latency_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_RESP_LATENCY: prdata = CFG_DATA_W'(resp_latency_reg);
            REG_QUEUE_LIMIT:  prdata = CFG_DATA_W'(queue_limit_reg);
            default:          prdata = '0;
        endcase
    end

    flme_front #(
        .MEM_WORDS (MEM_WORDS),
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .status        (status),
        .push_valid    (front_valid),
        .push_ready    (front_ready),
        .push_flags    (front_flags),
        .push_address  (front_address),
        .push_word     (front_word),
        .push_data     (front_data)
    );

    assign fifo_in = {front_flags, front_address, front_word, front_data};

    flme_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (fifo_in),
        .pop_valid  (cmd_valid),
        .pop        (cmd_pop),
        .pop_data   (fifo_out)
    );

    assign cmd_data    = fifo_out[DATA_BITS-1:0];
    assign cmd_word    = fifo_out[DATA_BITS +: MEM_AW];
    assign cmd_address = fifo_out[DATA_BITS + MEM_AW +: ADDR_W];
    assign cmd_flags   = cmd_flags_t'(fifo_out[CMD_W-1 -: FLAGS_W]);

    flme_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MEM_WORDS   (MEM_WORDS),
        .DATA_BITS   (DATA_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .resp_latency  (resp_latency_reg),
        .queue_limit   (queue_limit_reg),
        .cmd_valid     (cmd_valid),
        .cmd_flags     (cmd_flags),
        .cmd_address   (cmd_address),
        .cmd_word      (cmd_word),
        .cmd_data      (cmd_data),
        .cmd_pop       (cmd_pop),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
